// ===== hdl/layer_blend_composite_pixel_top_macros.svh =====
// Assertion macros for the layer blend compositor checkers.
// Used by files that include this header; expects clk and arst_n in scope.
`ifndef LAYER_BLEND_COMPOSITE_PIXEL_TOP_MACROS_SVH
`define LAYER_BLEND_COMPOSITE_PIXEL_TOP_MACROS_SVH

// same-cycle implication
`define LBC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LBC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/lbc_pkg.sv =====
// Shared types and constants for the layer blend compositor.
// No dependencies; imported by every RTL module.
package lbc_pkg;

	typedef logic [7:0] chan_t;
	typedef chan_t [3:0] pix_t;		// [0] red, [1] green, [2] blue, [3] alpha

	localparam int NCOL = 3;

	typedef logic [2:0] mode_t;
	localparam mode_t MODE_NORMAL   = 3'd0;
	localparam mode_t MODE_MULTIPLY = 3'd1;
	localparam mode_t MODE_SCREEN   = 3'd2;
	localparam mode_t MODE_OVERLAY  = 3'd3;
	localparam mode_t MODE_DARKEN   = 3'd4;
	localparam mode_t MODE_LIGHTEN  = 3'd5;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_BLEND_MODE = 2'd0;
	localparam reg_idx_t REG_STRENGTH   = 2'd1;
	localparam reg_idx_t REG_LAYER_KIND = 2'd2;

	localparam logic KIND_FILTER = 1'b0;
	localparam logic KIND_SOURCE = 1'b1;

	localparam logic [6:0] PCT_FULL = 7'd100;

	// reciprocal constants: floor(v / d) = (v * R) >> S over the value ranges used
	localparam logic [18:0] RECIP_510  = 19'd263173;
	localparam logic [12:0] RECIP_100  = 13'd5243;
	localparam logic [23:0] RECIP_100W = 24'd10737419;
	localparam logic [16:0] RECIP_255  = 17'd65794;

	localparam logic [23:0] FULL_Q16   = 24'd16711680;
	localparam logic [14:0] A_FULL     = 15'd25500;
	localparam logic [22:0] HALF_ALPHA = 23'd12750;
	localparam logic [30:0] HALF_FILT  = 31'd3276800;

	localparam int QBITS = 9;
	localparam int DVD_W = 49;
	localparam int DVS_W = 39;

	typedef logic [QBITS-1:0] quot_t;
	typedef logic [DVD_W-1:0] dvd_t;
	typedef logic [DVS_W-1:0] dvs_t;

	typedef struct packed {
		mode_t      mode;
		logic [6:0] pct;
		logic       kind;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic        pzero;
		logic        nzero;
		pix_t        base;
		quot_t [3:0] fq;
		quot_t       sa;
	} side_t;

	typedef struct packed {
		side_t       side;
		dvd_t [2:0]  dvd;
		dvs_t        dvs;
	} front_t;

	function automatic chan_t clamp8(quot_t q);
		return (q > quot_t'(255)) ? 8'hFF : q[7:0];
	endfunction

endpackage

// ===== hdl/lbc_in_if.sv =====
// Input channel: base and top RGBA pixel pair with valid/ready.
// No dependencies.
interface lbc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] base_red;
	logic [7:0] base_green;
	logic [7:0] base_blue;
	logic [7:0] base_alpha;
	logic [7:0] top_red;
	logic [7:0] top_green;
	logic [7:0] top_blue;
	logic [7:0] top_alpha;

	modport source (output valid, base_red, base_green, base_blue, base_alpha,
		top_red, top_green, top_blue, top_alpha, input ready);
	modport sink (input valid, base_red, base_green, base_blue, base_alpha,
		top_red, top_green, top_blue, top_alpha, output ready);
endinterface

// ===== hdl/lbc_out_if.sv =====
// Output channel: composited RGBA pixel with valid/ready.
// No dependencies.
interface lbc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;

	modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

// ===== hdl/layer_blend_composite_pixel_top.sv =====
// Layer blend compositor top level: config registers, front pipeline,
// per-channel color dividers and output register.
// Depends on lbc_pkg, lbc_in_if, lbc_out_if, lbc_front, lbc_div.
//
// Usage:
//   pix_in carries a base and a top RGBA pixel per beat; pix_out returns the
//   composited RGBA pixel, one result beat per input beat, in order.
//   Config (wr_en, wr_index, wr_data) sets blend mode, strength and layer kind;
//   write it only while the pipe is empty.
//   Pipeline: five arithmetic stages, nine divider stages, one output register.
//   Throughput: one beat per cycle unless stalled; the whole pipe advances together,
//   held by a single enable set by the output register and pix_out.ready.
//   Stall: while pix_out.valid is high and pix_out.ready low, pix_in.ready is
//   low and every stage holds; nothing is lost or repeated.
//   Reset: all valid bits clear; blend mode normal, strength 100, source layer.
module layer_blend_composite_pixel_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  lbc_pkg::reg_idx_t wr_index,
	input  logic [6:0]       wr_data,
	lbc_in_if.sink           pix_in,
	lbc_out_if.source        pix_out
);
	import lbc_pkg::*;

	mode_t      mode_q;
	logic [6:0] pct_q;
	logic       kind_q;
	cfg_t       cfg;
	logic       adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			pct_q  <= PCT_FULL;
			kind_q <= KIND_SOURCE;
		end else if (wr_en) begin
			case (wr_index)
				REG_BLEND_MODE: mode_q <= wr_data[2:0];
				REG_STRENGTH:   pct_q  <= wr_data;
				REG_LAYER_KIND: kind_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.mode = mode_q;
	assign cfg.pct  = (pct_q > PCT_FULL) ? PCT_FULL : pct_q;
	assign cfg.kind = kind_q;

	logic   out_v_q;
	pix_t   out_q;
	pix_t   base_in, top_in;
	logic   f_valid;
	front_t f_data;

	assign adv          = !out_v_q || pix_out.ready;
	assign pix_in.ready = adv;

	assign base_in = {pix_in.base_alpha, pix_in.base_blue, pix_in.base_green, pix_in.base_red};
	assign top_in  = {pix_in.top_alpha, pix_in.top_blue, pix_in.top_green, pix_in.top_red};

	lbc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (pix_in.valid),
		.base     (base_in),
		.top      (top_in),
		.cfg      (cfg),
		.out_valid(f_valid),
		.out_data (f_data)
	);

	quot_t [2:0] quot;

	for (genvar c = 0; c < NCOL; c++) begin : g_div
		lbc_div u_div (
			.clk (clk),
			.adv (adv),
			.dvd (f_data.dvd[c]),
			.dvs (f_data.dvs),
			.quot(quot[c])
		);
	end

	// sideband rides beside the dividers
	logic [QBITS-1:0] vd_s;
	side_t            side_s [QBITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd_s <= '0;
		end else if (adv) begin
			vd_s <= {vd_s[QBITS-2:0], f_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= f_data.side;
			for (int i = 1; i < QBITS; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	side_t sd;
	pix_t  res;

	assign sd = side_s[QBITS-1];

	always_comb begin
		for (int c = 0; c < NCOL; c++) begin
			if (sd.pzero) begin
				res[c] = sd.base[c];
			end else if (sd.kind == KIND_FILTER) begin
				res[c] = clamp8(sd.fq[c]);
			end else if (sd.nzero) begin
				res[c] = '0;
			end else begin
				res[c] = clamp8(quot[c]);
			end
		end
		if (sd.pzero) begin
			res[3] = sd.base[3];
		end else if (sd.kind == KIND_FILTER) begin
			res[3] = clamp8(sd.fq[3]);
		end else begin
			res[3] = clamp8(sd.sa);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= vd_s[QBITS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign pix_out.valid     = out_v_q;
	assign pix_out.out_red   = out_q[0];
	assign pix_out.out_green = out_q[1];
	assign pix_out.out_blue  = out_q[2];
	assign pix_out.out_alpha = out_q[3];

endmodule

// ===== hdl/lbc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, rounded half up upstream.
// Depends on lbc_pkg.
module lbc_div (
	input  logic         clk,
	input  logic         adv,
	input  lbc_pkg::dvd_t dvd,
	input  lbc_pkg::dvs_t dvs,
	output lbc_pkg::quot_t quot
);
	import lbc_pkg::*;

	dvd_t  rem_s [QBITS-1];
	dvs_t  den_s [QBITS-1];
	quot_t q_s   [QBITS];

	for (genvar i = 0; i < QBITS; i++) begin : g_stage
		localparam int SH = QBITS - 1 - i;
		dvd_t  rem_in;
		dvs_t  den_in;
		quot_t q_in;
		dvd_t  cmp;
		dvd_t  rem_nxt;
		quot_t q_nxt;

		if (i == 0) begin : g_first
			assign rem_in = dvd;
			assign den_in = dvs;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign den_in = den_s[i-1];
			assign q_in   = q_s[i-1];
		end

		always_comb begin
			cmp     = DVD_W'({den_in, 1'b0}) << SH;
			rem_nxt = rem_in;
			q_nxt   = q_in;
			if (rem_in >= cmp) begin
				rem_nxt   = rem_in - cmp;
				q_nxt[SH] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				q_s[i] <= q_nxt;
			end
		end

		if (i < QBITS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[i] <= rem_nxt;
					den_s[i] <= den_in;
				end
			end
		end
	end

	assign quot = q_s[QBITS-1];

endmodule

// ===== hdl/lbc_front.sv =====
// Front pipeline (five stages): blend value, coverage weights, products,
// filter and alpha quotients, and dividend/divisor for the color divide.
// Depends on lbc_pkg.
module lbc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_valid,
	input  lbc_pkg::pix_t   base,
	input  lbc_pkg::pix_t   top,
	input  lbc_pkg::cfg_t   cfg,
	output logic            out_valid,
	output lbc_pkg::front_t out_data
);
	import lbc_pkg::*;

	// stage 1
	logic [2:0][16:0] m_c;
	logic [2:0]       inv_c;
	logic [14:0]      x_c;
	logic             v_s1;
	pix_t             base_s1, top_s1;
	cfg_t             cfg_s1;
	logic [2:0][16:0] m_s1;
	logic [2:0]       inv_s1;
	logic [14:0]      x_s1;

	always_comb begin
		logic [15:0] lo;
		logic [15:0] hi;
		for (int c = 0; c < NCOL; c++) begin
			lo       = 16'(base[c]) * 16'(top[c]);
			hi       = 16'(8'd255 - base[c]) * 16'(8'd255 - top[c]);
			m_c[c]   = '0;
			inv_c[c] = 1'b0;
			case (cfg.mode)
				MODE_MULTIPLY: m_c[c] = 17'(lo);
				MODE_SCREEN: begin
					m_c[c]   = 17'(hi);
					inv_c[c] = 1'b1;
				end
				MODE_OVERLAY: begin
					if (base[c] <= 8'd127) begin
						m_c[c] = {lo, 1'b0};
					end else begin
						m_c[c]   = {hi, 1'b0};
						inv_c[c] = 1'b1;
					end
				end
				default: ;
			endcase
		end
		x_c = 15'(top[3]) * 15'(cfg.pct);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			base_s1 <= base;
			top_s1  <= top;
			cfg_s1  <= cfg;
			m_s1    <= m_c;
			inv_s1  <= inv_c;
			x_s1    <= x_c;
		end
	end

	// stage 2
	logic [2:0][24:0] raw_c;
	logic [22:0]      xy_c, xa_c, xb_c, x255_c;
	logic [16:0]      fa_c;
	logic             v_s2;
	pix_t             base_s2, top_s2;
	cfg_t             cfg_s2;
	logic [2:0][24:0] raw_s2;
	logic [2:0]       inv_s2;
	logic [22:0]      xy_s2, xa_s2, xb_s2, x255_s2;
	logic [16:0]      fa_s2;

	always_comb begin
		logic [17:0] k;
		logic [36:0] prod;
		for (int c = 0; c < NCOL; c++) begin
			k        = {m_s1[c], 1'b0} + 18'd255;
			prod     = 37'(k) * 37'(RECIP_510);
			raw_c[c] = 25'({m_s1[c], 8'h00}) + 25'(m_s1[c]) + 25'(prod[36:27]);
		end
		xy_c   = 23'(x_s1) * 23'(base_s1[3]);
		xa_c   = 23'(x_s1) * 23'(8'd255 - base_s1[3]);
		xb_c   = 23'(A_FULL - x_s1) * 23'(base_s1[3]);
		x255_c = 23'({x_s1, 8'h00}) - 23'(x_s1);
		fa_c   = 17'(base_s1[3]) * 17'd100 + 17'(cfg_s1.pct) * 17'(top_s1[3])
			- 17'(cfg_s1.pct) * 17'(base_s1[3]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			base_s2 <= base_s1;
			top_s2  <= top_s1;
			cfg_s2  <= cfg_s1;
			raw_s2  <= raw_c;
			inv_s2  <= inv_s1;
			xy_s2   <= xy_c;
			xa_s2   <= xa_c;
			xb_s2   <= xb_c;
			x255_s2 <= x255_c;
			fa_s2   <= fa_c;
		end
	end

	// stage 3
	logic [2:0][23:0] bq_c;
	logic [22:0]      nao_c;
	logic [27:0]      fqa_prod;
	logic             v_s3;
	pix_t             base_s3, top_s3;
	cfg_t             cfg_s3;
	logic [2:0][23:0] bq_s3;
	logic [22:0]      nao_s3, xy_s3, xa_s3, xb_s3;
	quot_t            fqa_s3;

	always_comb begin
		for (int c = 0; c < NCOL; c++) begin
			case (cfg_s2.mode)
				MODE_MULTIPLY, MODE_SCREEN, MODE_OVERLAY:
					bq_c[c] = inv_s2[c] ? FULL_Q16 - 24'(raw_s2[c]) : 24'(raw_s2[c]);
				MODE_DARKEN:
					bq_c[c] = {(base_s2[c] < top_s2[c]) ? base_s2[c] : top_s2[c], 16'h0000};
				MODE_LIGHTEN:
					bq_c[c] = {(base_s2[c] > top_s2[c]) ? base_s2[c] : top_s2[c], 16'h0000};
				default:
					bq_c[c] = {top_s2[c], 16'h0000};
			endcase
		end
		nao_c    = x255_s2 + xb_s2;
		fqa_prod = 28'(fa_s2 + 17'd50) * 28'(RECIP_100);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			base_s3 <= base_s2;
			top_s3  <= top_s2;
			cfg_s3  <= cfg_s2;
			bq_s3   <= bq_c;
			nao_s3  <= nao_c;
			xy_s3   <= xy_s2;
			xa_s3   <= xa_s2;
			xb_s3   <= xb_s2;
			fqa_s3  <= fqa_prod[27:19];
		end
	end

	// stage 4
	logic [2:0][30:0] t1_c, t3_c, fn_c;
	logic [2:0][46:0] t2_c;
	logic [46:0]      w_prod;
	logic             v_s4;
	pix_t             base_s4;
	cfg_t             cfg_s4;
	logic [2:0][30:0] t1_s4, t3_s4, fn_s4;
	logic [2:0][46:0] t2_s4;
	logic [16:0]      w_s4;
	logic [22:0]      nao_s4;
	quot_t            fqa_s4;

	always_comb begin
		logic [23:0] b16;
		for (int c = 0; c < NCOL; c++) begin
			b16     = {base_s3[c], 16'h0000};
			t1_c[c] = 31'(xa_s3) * 31'(top_s3[c]);
			t2_c[c] = 47'(xy_s3) * 47'(bq_s3[c]);
			t3_c[c] = 31'(xb_s3) * 31'(base_s3[c]);
			fn_c[c] = 31'(b16) * 31'd100 + 31'(cfg_s3.pct) * 31'(bq_s3[c])
				- 31'(cfg_s3.pct) * 31'(b16);
		end
		w_prod = 47'(nao_s3 + HALF_ALPHA) * 47'(RECIP_100W);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			base_s4 <= base_s3;
			cfg_s4  <= cfg_s3;
			t1_s4   <= t1_c;
			t2_s4   <= t2_c;
			t3_s4   <= t3_c;
			fn_s4   <= fn_c;
			w_s4    <= w_prod[46:30];
			nao_s4  <= nao_s3;
			fqa_s4  <= fqa_s3;
		end
	end

	// stage 5
	front_t      f_c;
	logic [33:0] sa_prod;
	logic        v_s5;
	front_t      f_s5;

	always_comb begin
		logic [47:0] num;
		logic [30:0] fsum;
		logic [27:0] fprod;
		f_c.dvs = {nao_s4, 16'h0000};
		for (int c = 0; c < NCOL; c++) begin
			num         = 48'({t1_s4[c], 16'h0000}) + 48'(t2_s4[c])
				+ 48'({t3_s4[c], 16'h0000});
			f_c.dvd[c]  = DVD_W'({num, 1'b0}) + DVD_W'(f_c.dvs);
			fsum        = fn_s4[c] + HALF_FILT;
			fprod       = 28'(fsum[30:16]) * 28'(RECIP_100);
			f_c.side.fq[c] = fprod[27:19];
		end
		f_c.side.fq[3] = fqa_s4;
		sa_prod        = 34'(w_s4) * 34'(RECIP_255);
		f_c.side.sa    = sa_prod[32:24];
		f_c.side.kind  = cfg_s4.kind;
		f_c.side.pzero = (cfg_s4.pct == '0);
		f_c.side.nzero = (nao_s4 == '0);
		f_c.side.base  = base_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s5 <= f_c;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = f_s5;

endmodule

// ===== hdl/lbc_checker.sv =====
// Port-level checker for the layer blend compositor, bound to the top level.
// Depends on layer_blend_composite_pixel_top_macros.svh.
`include "layer_blend_composite_pixel_top_macros.svh"

module lbc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue,
	input logic [7:0] out_alpha
);

	logic [31:0] out_pix;

	assign out_pix = {out_red, out_green, out_blue, out_alpha};

	// a stalled result beat holds
	`LBC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pix), "stalled result beat changed")

	// empty output register never blocks input
	`LBC_ASSERT_NOW(a_ready_idle, !out_valid, in_ready, "input blocked with output empty")

	// input only backs up behind a stalled output
	`LBC_ASSERT_NOW(a_ready_stall, !in_ready, out_valid && !out_ready, "input blocked without output stall")

	// handshake valids are always known out of reset
	`LBC_ASSERT_NOW(a_valid_known, 1'b1, !$isunknown({in_valid, out_valid}), "valid unknown")

endmodule

bind layer_blend_composite_pixel_top lbc_checker u_lbc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (pix_in.valid),
	.in_ready (pix_in.ready),
	.out_valid(pix_out.valid),
	.out_ready(pix_out.ready),
	.out_red  (pix_out.out_red),
	.out_green(pix_out.out_green),
	.out_blue (pix_out.out_blue),
	.out_alpha(pix_out.out_alpha)
);
